// File: design/dsm_pkg.sv
// Shared types and constants for the DFA state minimizer.
// Word layouts of both channels, controller/datapath command and status.
`default_nettype none

package dsm_pkg;

  localparam int IDX_W      = 5;
  localparam int SYM_W      = 3;
  localparam int CLS_W      = 6;
  localparam int CNT_W      = 6;
  localparam int MCNT_W     = 4;
  localparam int FLD_W      = 6;
  localparam int ROW_W      = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CLS_W-1:0] CLS_NONE = 6'h3F;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd2;

  typedef struct packed {
    logic [4:0]       state_index;
    logic             state_final;
    logic [ROW_W-1:0] row_targets;
    logic             last;
  } dsm_in_t;

  typedef struct packed {
    logic [4:0]       class_index;
    logic             class_final;
    logic [ROW_W-1:0] class_targets;
    logic [4:0]       start_class;
    logic [CNT_W-1:0] class_total;
    logic             end_of_rows;
  } dsm_out_t;

  typedef struct packed {
    logic             load;
    logic             init;
    logic             reach_step;
    logic             chg_clr;
    logic             class0;
    logic             key_cur;
    logic             key_sym;
    logic             scan;
    logic             scan_new;
    logic             scan_copy;
    logic             update;
    logic             startc;
    logic             em_pick;
    logic             em_sym;
    logic             out_load;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [SYM_W-1:0] s;
  } dsm_cmd_t;

  typedef struct packed {
    logic              start_bad;
    logic              reach_more;
    logic              curi_none;
    logic              match;
    logic              round_chg;
    logic              is_rep;
    logic              out_free;
    logic              em_last;
    logic [CNT_W-1:0]  n_eff;
    logic [MCNT_W-1:0] m_eff;
  } dsm_sts_t;

endpackage

`default_nettype wire

// File: design/dsm_ctrl.sv
// Sequencer of the DFA state minimizer: state machine and loop counters.
// Depends on dsm_pkg; drives the datapath through dsm_cmd_t.
`default_nettype none

module dsm_ctrl #(
  parameter int MAX_STATES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last,
  output logic              in_ready,
  input  dsm_pkg::dsm_sts_t sts,
  output dsm_pkg::dsm_cmd_t cmd
);
  import dsm_pkg::*;

  localparam int ROUND_CAP = MAX_STATES + 2;
  localparam int ITER_W    = $clog2(ROUND_CAP + 1);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_INIT   = 12'b000000000010,
    S_REACH  = 12'b000000000100,
    S_CLASS0 = 12'b000000001000,
    S_KEYCUR = 12'b000000010000,
    S_KEYSYM = 12'b000000100000,
    S_SCAN   = 12'b000001000000,
    S_UPDATE = 12'b000010000000,
    S_STARTC = 12'b000100000000,
    S_EMSCAN = 12'b001000000000,
    S_EMSYM  = 12'b010000000000,
    S_EMOUT  = 12'b100000000000
  } dsm_state_t;

  dsm_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]  i_r, i_nxt;
  logic [IDX_W-1:0]  j_r, j_nxt;
  logic [SYM_W-1:0]  s_r, s_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;

  logic              i_last;
  logic              s_last;
  logic              m_zero;
  logic [ITER_W-1:0] iter_inc;
  logic              round_more;

  assign i_last     = (CNT_W'(i_r) + CNT_W'(1)) == sts.n_eff;
  assign s_last     = (MCNT_W'(s_r) + MCNT_W'(1)) == sts.m_eff;
  assign m_zero     = sts.m_eff == '0;
  assign iter_inc   = iter_r + ITER_W'(1);
  assign round_more = sts.round_chg && (iter_inc < ITER_W'(ROUND_CAP));

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    s_nxt     = s_r;
    iter_nxt  = iter_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.i     = i_r;
    cmd.j     = j_r;
    cmd.s     = s_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        cmd.init = 1'b1;
        i_nxt    = '0;
        state_nxt = sts.start_bad ? S_IDLE : S_REACH;
      end
      S_REACH: begin
        cmd.reach_step = 1'b1;
        if (i_last) begin
          i_nxt = '0;
          if (sts.reach_more) begin
            cmd.chg_clr = 1'b1;
          end else begin
            state_nxt = S_CLASS0;
          end
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      S_CLASS0: begin
        cmd.class0 = 1'b1;
        i_nxt      = '0;
        iter_nxt   = '0;
        state_nxt  = S_KEYCUR;
      end
      S_KEYCUR: begin
        cmd.key_cur = 1'b1;
        s_nxt       = '0;
        j_nxt       = '0;
        state_nxt   = m_zero ? S_SCAN : S_KEYSYM;
      end
      S_KEYSYM: begin
        cmd.key_sym = 1'b1;
        if (s_last) begin
          state_nxt = S_SCAN;
        end else begin
          s_nxt = s_r + SYM_W'(1);
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.curi_none || j_r == i_r || sts.match) begin
          if (!sts.curi_none) begin
            if (j_r == i_r) begin
              cmd.scan_new = 1'b1;
            end else begin
              cmd.scan_copy = 1'b1;
            end
          end
          if (i_last) begin
            state_nxt = S_UPDATE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_KEYCUR;
          end
        end else begin
          j_nxt = j_r + IDX_W'(1);
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        iter_nxt   = iter_inc;
        i_nxt      = '0;
        state_nxt  = round_more ? S_KEYCUR : S_STARTC;
      end
      S_STARTC: begin
        cmd.startc = 1'b1;
        i_nxt      = '0;
        state_nxt  = S_EMSCAN;
      end
      S_EMSCAN: begin
        if (sts.is_rep) begin
          cmd.em_pick = 1'b1;
          s_nxt       = '0;
          state_nxt   = m_zero ? S_EMOUT : S_EMSYM;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      S_EMSYM: begin
        cmd.em_sym = 1'b1;
        if (s_last) begin
          state_nxt = S_EMOUT;
        end else begin
          s_nxt = s_r + SYM_W'(1);
        end
      end
      S_EMOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.em_last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt     = i_r + IDX_W'(1);
            state_nxt = S_EMSCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      s_r     <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      s_r     <= s_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/dsm_dpath.sv
// Datapath of the DFA state minimizer: row store, class tables, key store,
// configuration registers and output register. Depends on dsm_pkg.
`default_nettype none

module dsm_dpath #(
  parameter int MAX_STATES  = 32,
  parameter int MAX_SYMBOLS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [dsm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dsm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  dsm_pkg::dsm_in_t                    in_data,
  input  dsm_pkg::dsm_cmd_t                   cmd,
  output dsm_pkg::dsm_sts_t                   sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output dsm_pkg::dsm_out_t                   out_data
);
  import dsm_pkg::*;

  localparam int SW = $clog2(MAX_STATES);

  logic [ROW_W-1:0]      rows_r  [MAX_STATES];
  logic [ROW_W-1:0]      key_mem [MAX_STATES];
  logic [CLS_W-1:0]      cur_r   [MAX_STATES];
  logic [CLS_W-1:0]      refc_r  [MAX_STATES];
  logic [MAX_STATES-1:0] fin_r;
  logic [MAX_STATES-1:0] reach_r;

  logic [CNT_W-1:0]  st_cnt_r;
  logic [MCNT_W-1:0] sym_cnt_r;
  logic [4:0]        start_r;

  logic              chg_r;
  logic [CLS_W-1:0]  curi_r;
  logic [ROW_W-1:0]  key_r;
  logic [CLS_W-1:0]  cls_cnt_r;
  logic [CNT_W-1:0]  total_r;
  logic [4:0]        start_cls_r;
  logic [CLS_W-1:0]  emc_r;
  logic              emfin_r;
  logic              out_valid_r;
  dsm_out_t          out_data_r;

  logic [CNT_W-1:0]      n_eff;
  logic [MCNT_W-1:0]     m_eff;
  logic [SW-1:0]         ii;
  logic [SW-1:0]         jj;
  logic [ROW_W-1:0]      row_i;
  logic [FLD_W-1:0]      fld;
  logic                  t_ok;
  logic [SW-1:0]         cur_addr;
  logic [CLS_W-1:0]      cur_rd;
  logic [CLS_W-1:0]      succ;
  logic [MAX_STATES-1:0] reach_new;
  logic [MAX_STATES-1:0] reach_add;
  logic [MAX_STATES-1:0] reach_init;
  logic                  start_bad;
  logic                  round_chg;
  logic                  em_last;
  logic                  idx_ok;

  assign n_eff = (st_cnt_r > CNT_W'(MAX_STATES)) ? CNT_W'(MAX_STATES) : st_cnt_r;
  assign m_eff = (sym_cnt_r > MCNT_W'(MAX_SYMBOLS)) ? MCNT_W'(MAX_SYMBOLS) : sym_cnt_r;
  assign ii    = cmd.i[SW-1:0];
  assign jj    = cmd.j[SW-1:0];
  assign row_i = rows_r[ii];
  assign fld   = row_i[cmd.s*FLD_W +: FLD_W];
  assign t_ok  = fld[FLD_W-1] && (CNT_W'(fld[4:0]) < n_eff);
  assign start_bad = CNT_W'(start_r) >= n_eff;
  assign idx_ok    = CNT_W'(in_data.state_index) < CNT_W'(MAX_STATES);
  assign em_last   = (CNT_W'(emc_r) + CNT_W'(1)) == total_r;

  always_comb begin
    if (cmd.key_sym || cmd.em_sym) begin
      cur_addr = fld[SW-1:0];
    end else if (cmd.scan) begin
      cur_addr = jj;
    end else if (cmd.startc) begin
      cur_addr = start_r[SW-1:0];
    end else begin
      cur_addr = ii;
    end
  end

  assign cur_rd = cur_r[cur_addr];
  assign succ   = t_ok ? cur_rd : CLS_NONE;

  always_comb begin
    logic [FLD_W-1:0] f;
    reach_new = '0;
    for (int k = 0; k < MAX_SYMBOLS; k++) begin
      f = row_i[k*FLD_W +: FLD_W];
      if ((MCNT_W'(k) < m_eff) && f[FLD_W-1] && (CNT_W'(f[4:0]) < n_eff)) begin
        reach_new[f[SW-1:0]] = 1'b1;
      end
    end
    if (!reach_r[ii]) begin
      reach_new = '0;
    end
  end

  assign reach_add = reach_new & ~reach_r;

  always_comb begin
    reach_init = '0;
    reach_init[start_r[SW-1:0]] = 1'b1;
  end

  always_comb begin
    round_chg = 1'b0;
    for (int k = 0; k < MAX_STATES; k++) begin
      if (cur_r[k] != refc_r[k]) begin
        round_chg = 1'b1;
      end
    end
  end

  assign sts.start_bad  = start_bad;
  assign sts.reach_more = chg_r || (|reach_add);
  assign sts.curi_none  = curi_r == CLS_NONE;
  assign sts.match      = (cur_rd != CLS_NONE) && (cur_rd == curi_r) && (key_mem[jj] == key_r);
  assign sts.round_chg  = round_chg;
  assign sts.is_rep     = cur_rd == emc_r;
  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.em_last    = em_last;
  assign sts.n_eff      = n_eff;
  assign sts.m_eff      = m_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_cnt_r  <= CNT_W'(1);
      sym_cnt_r <= MCNT_W'(2);
      start_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATE_COUNT:  st_cnt_r  <= cfg_wdata[CNT_W-1:0];
        CFG_SYMBOL_COUNT: sym_cnt_r <= cfg_wdata[MCNT_W-1:0];
        CFG_START_STATE:  start_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && idx_ok) begin
      rows_r[in_data.state_index[SW-1:0]] <= in_data.row_targets;
      fin_r[in_data.state_index[SW-1:0]]  <= in_data.state_final;
    end
    if (cmd.scan) begin
      key_mem[ii] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reach_r <= '0;
      chg_r   <= 1'b0;
    end else if (cmd.init) begin
      reach_r <= start_bad ? '0 : reach_init;
      chg_r   <= 1'b0;
    end else if (cmd.reach_step) begin
      reach_r <= reach_r | reach_add;
      chg_r   <= cmd.chg_clr ? 1'b0 : (chg_r || (|reach_add));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_STATES; k++) begin
        cur_r[k]  <= CLS_NONE;
        refc_r[k] <= CLS_NONE;
      end
    end else if (cmd.init) begin
      for (int k = 0; k < MAX_STATES; k++) begin
        cur_r[k]  <= CLS_NONE;
        refc_r[k] <= CLS_NONE;
      end
    end else if (cmd.class0) begin
      for (int k = 0; k < MAX_STATES; k++) begin
        cur_r[k]  <= reach_r[k] ? {{(CLS_W-1){1'b0}}, fin_r[k]} : CLS_NONE;
        refc_r[k] <= CLS_NONE;
      end
    end else if (cmd.update) begin
      for (int k = 0; k < MAX_STATES; k++) begin
        cur_r[k]  <= refc_r[k];
        refc_r[k] <= CLS_NONE;
      end
    end else if (cmd.scan_new) begin
      refc_r[ii] <= cls_cnt_r;
    end else if (cmd.scan_copy) begin
      refc_r[ii] <= refc_r[jj];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_cnt_r <= '0;
      total_r   <= '0;
      emc_r     <= '0;
    end else begin
      if (cmd.class0 || cmd.update) begin
        cls_cnt_r <= '0;
      end else if (cmd.scan_new) begin
        cls_cnt_r <= cls_cnt_r + CLS_W'(1);
      end
      if (cmd.update) begin
        total_r <= cls_cnt_r;
      end
      if (cmd.startc) begin
        emc_r <= '0;
      end else if (cmd.out_load) begin
        emc_r <= emc_r + CLS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.key_cur) begin
      curi_r <= cur_rd;
      key_r  <= '1;
    end else if (cmd.key_sym) begin
      key_r[cmd.s*FLD_W +: FLD_W] <= succ;
    end else if (cmd.em_pick) begin
      emfin_r <= fin_r[ii];
      key_r   <= '0;
    end else if (cmd.em_sym) begin
      key_r[cmd.s*FLD_W +: FLD_W] <= (succ != CLS_NONE) ? {1'b1, succ[4:0]} : '0;
    end
    if (cmd.startc) begin
      start_cls_r <= cur_rd[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.class_index   <= emc_r[4:0];
      out_data_r.class_final   <= emfin_r;
      out_data_r.class_targets <= key_r;
      out_data_r.start_class   <= start_cls_r;
      out_data_r.class_total   <= total_r;
      out_data_r.end_of_rows   <= em_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// File: design/dfa_state_minimizer.sv
// DFA state minimizer top level: controller, datapath and checks.
// Depends on dsm_pkg, dsm_ctrl and dsm_dpath.
//
// Rows load at one word per cycle; a word with last set starts a run and the
// input stays closed until the run's final class word enters the output
// register. With n states and m symbols a run consists of: reachability passes
// over the n states, up to n passes; per refinement round, for each state i a
// key over the m symbols and compares with states up to i, up to MAX_STATES + 2
// rounds; then a scan of the states with a class word built over the m symbols
// for each class emitted. One class table read port and one key compare are
// shared by all steps. A pending output word does not block the next rows.
`default_nettype none

module dfa_state_minimizer #(
  parameter int MAX_STATES  = 32,
  parameter int MAX_SYMBOLS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  dsm_pkg::dsm_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output dsm_pkg::dsm_out_t              out_data
);
  import dsm_pkg::*;

  dsm_cmd_t cmd;
  dsm_sts_t sts;

  dsm_ctrl #(
    .MAX_STATES (MAX_STATES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dsm_dpath #(
    .MAX_STATES  (MAX_STATES),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output word overwritten while pending");

  a_class_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.init, cmd.class0, cmd.update, cmd.scan_new, cmd.scan_copy}))
    else $error("conflicting class table writes");

  a_last_row_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.end_of_rows) |->
      ((CNT_W'(out_data.class_index) + CNT_W'(1)) == out_data.class_total))
    else $error("end of rows does not match class total");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.scan || cmd.reach_step || cmd.em_sym))
    else $error("row load during a run");
`endif

endmodule

`default_nettype wire

// File: dv/tb_top.sv
// Testbench for dfa_state_minimizer: loads random DFA rows, predicts the minimized
// class words in a scoreboard and checks every output word in order.
// Depends on dsm_pkg and the dfa_state_minimizer RTL.
`timescale 1ns / 1ps

module tb_top;
  import dsm_pkg::*;

  localparam int NSTATES = 32;
  localparam int NSYMS   = 8;
  localparam int NO_CLS  = 63;
  localparam int QUIET_LIMIT = 400000;

  class dfa_scoreboard;
    logic [ROW_W-1:0] rows[NSTATES];
    bit               finals[NSTATES];
    int               cfg_states = 1;
    int               cfg_syms   = 2;
    int               cfg_start  = 0;
    dsm_out_t         class_q[$];
    int               mismatches;
    int               checked;

    function int succ_state(int i, int s, int n);
      logic [5:0] f;
      f = rows[i][6*s +: 6];
      if (!f[5] || f[4:0] >= n) return NO_CLS;
      return f[4:0];
    endfunction

    function void set_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_STATE_COUNT:  cfg_states = int'(val);
        CFG_SYMBOL_COUNT: cfg_syms   = int'(val[3:0]);
        CFG_START_STATE:  cfg_start  = int'(val[4:0]);
        default: ;
      endcase
    endfunction

    function void note_input(dsm_in_t w);
      int n, m, classes, t, c, rep;
      int reach[NSTATES];
      int cur[NSTATES];
      int nxt[NSTATES];
      int member[NSTATES];
      bit changed, same;
      dsm_out_t r;
      rows[w.state_index]   = w.row_targets;
      finals[w.state_index] = w.state_final;
      if (!w.last) return;
      n = (cfg_states > NSTATES) ? NSTATES : cfg_states;
      m = (cfg_syms > NSYMS) ? NSYMS : cfg_syms;
      if (cfg_start >= n) return;
      foreach (reach[i]) begin
        reach[i] = 0;
        cur[i] = NO_CLS;
        member[i] = NO_CLS;
      end
      reach[cfg_start] = 1;
      changed = 1;
      while (changed) begin
        changed = 0;
        for (int i = 0; i < n; i++) begin
          if (reach[i]) begin
            for (int s = 0; s < m; s++) begin
              t = succ_state(i, s, n);
              if (t != NO_CLS && !reach[t]) begin
                reach[t] = 1;
                changed = 1;
              end
            end
          end
        end
      end
      for (int i = 0; i < n; i++) cur[i] = reach[i] ? finals[i] : NO_CLS;
      classes = 0;
      changed = 1;
      for (int it = 0; changed && it < NSTATES + 2; it++) begin
        changed = 0;
        classes = 0;
        foreach (nxt[i]) nxt[i] = NO_CLS;
        for (int i = 0; i < n; i++) begin
          if (cur[i] == NO_CLS || nxt[i] != NO_CLS) continue;
          nxt[i] = classes;
          for (int j = i + 1; j < n; j++) begin
            if (cur[j] == NO_CLS || nxt[j] != NO_CLS || cur[j] != cur[i]) continue;
            same = 1;
            for (int s = 0; s < m && same; s++) begin
              t = succ_state(i, s, n);
              c = succ_state(j, s, n);
              if ((t == NO_CLS ? NO_CLS : cur[t]) != (c == NO_CLS ? NO_CLS : cur[c]))
                same = 0;
            end
            if (same) nxt[j] = classes;
          end
          classes++;
        end
        for (int i = 0; i < n; i++) begin
          if (cur[i] != nxt[i]) changed = 1;
          cur[i] = nxt[i];
        end
      end
      for (int i = 0; i < n; i++)
        if (cur[i] < NSTATES && member[cur[i]] == NO_CLS) member[cur[i]] = i;
      for (int k = 0; k < classes && k < NSTATES; k++) begin
        rep = member[k] & 31;
        r = '0;
        for (int s = 0; s < m; s++) begin
          t = succ_state(rep, s, n);
          if (t != NO_CLS) r.class_targets[6*s +: 6] = {1'b1, 5'(cur[t])};
        end
        r.class_index = 5'(k);
        r.class_final = finals[rep];
        r.start_class = 5'(cur[cfg_start]);
        r.class_total = 6'(classes);
        r.end_of_rows = (k + 1 == classes);
        class_q.push_back(r);
      end
    endfunction

    function void check(dsm_out_t got);
      dsm_out_t want;
      checked++;
      if (class_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected class word %h", got);
        return;
      end
      want = class_q.pop_front();
      if (got.class_index !== want.class_index || got.class_final !== want.class_final ||
          got.class_targets !== want.class_targets || got.start_class !== want.start_class ||
          got.class_total !== want.class_total || got.end_of_rows !== want.end_of_rows) begin
        mismatches++;
        if (mismatches <= 10)
          $display("class word mismatch: expected %h, actual %h", want, got);
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic     in_valid;
  logic     in_ready;
  dsm_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  dsm_out_t out_data;

  dfa_state_minimizer i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  dfa_scoreboard sb;
  int tx_pct;
  int rx_pct;
  int words_in;
  int runs;
  int quiet;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    quiet = quiet + 1;
    if (in_valid && in_ready) quiet = 0;
    if (out_valid && out_ready) begin
      quiet = 0;
      sb.check(out_data);
    end
    out_ready <= ($urandom_range(99) >= rx_pct);
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_top: watchdog expired");
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_cfg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(int n, int m, int st);
    cfg_write(CFG_STATE_COUNT, CFG_DATA_W'(n));
    cfg_write(CFG_SYMBOL_COUNT, CFG_DATA_W'(m));
    cfg_write(CFG_START_STATE, CFG_DATA_W'(st));
  endtask

  task automatic send_word(dsm_in_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    sb.note_input(w);
    words_in++;
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  function automatic logic [ROW_W-1:0] make_row(int n, int kind);
    logic [ROW_W-1:0] r;
    if (kind == 1) return '1;
    if (kind == 2) return '0;
    if ($urandom_range(9) == 0) return ROW_W'({$urandom, $urandom});
    for (int s = 0; s < NSYMS; s++) begin
      r[6*s+5] = ($urandom_range(9) < 8);
      r[6*s +: 5] = ($urandom_range(9) < 8) ? 5'($urandom_range(n - 1)) :
                                              5'($urandom_range(31));
    end
    return r;
  endfunction

  task automatic run_dfa(int kind, bit noise);
    int n, m, tmp, k;
    int order[$];
    dsm_in_t w;
    n = (sb.cfg_states > NSTATES) ? NSTATES : sb.cfg_states;
    m = (sb.cfg_syms > NSYMS) ? NSYMS : sb.cfg_syms;
    if (noise) begin
      repeat ($urandom_range(1, 3)) begin
        w.state_index = 5'($urandom);
        w.state_final = 1'($urandom);
        w.row_targets = ROW_W'({$urandom, $urandom});
        w.last = 1'b0;
        send_word(w);
      end
    end
    for (int i = 0; i < n; i++) order.push_back(i);
    for (int i = n - 1; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      w.state_index = 5'(order[i]);
      w.state_final = (kind == 1) ? 1'b1 : (kind == 2) ? 1'b0 : 1'($urandom);
      w.row_targets = make_row(n, kind);
      w.last = (i == n - 1);
      send_word(w);
    end
    in_valid <= 1'b0;
    runs++;
    if (sb.class_q.size() == 0) begin
      repeat ((n + 2) * (n * (n + 1) / 2 + n * (m + 1)) + n * n + 100) @(posedge clk);
    end else begin
      while (sb.class_q.size() != 0) @(posedge clk);
    end
  endtask

  initial begin
    int n;
    sb = new;
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    tx_pct = 21;
    rx_pct = 59;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_dfa(0, 0);
    set_all(4, 1, 3);
    run_dfa(0, 0);
    set_all(40, 12, 31);
    run_dfa(0, 0);
    set_all(3, 8, 5);
    run_dfa(0, 0);
    set_all(2, 2, 1);
    run_dfa(1, 0);
    set_all(5, 8, 0);
    run_dfa(2, 0);

    while (words_in < 160) begin
      if (words_in > 120) begin
        tx_pct = 0;
        rx_pct = 0;
      end else if (words_in > 80) begin
        tx_pct = 59;
        rx_pct = 21;
      end
      n = ($urandom_range(19) == 0) ? 32 : $urandom_range(1, 8);
      set_all(n, $urandom_range(1, 8),
              ($urandom_range(9) == 0) ? $urandom_range(n, 31) : $urandom_range(n - 1));
      repeat ($urandom_range(1, 3)) run_dfa(0, $urandom_range(5) == 0);
    end

    while (sb.class_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("tb_top: %0d row words in %0d runs, %0d class words checked, %0d mismatches",
             words_in, runs, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.class_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: dfa_state_minimizer.f
design/dsm_pkg.sv
design/dsm_ctrl.sv
design/dsm_dpath.sv
design/dfa_state_minimizer.sv
dv/tb_top.sv
